// ----- src/smac_pkg.sv -----
// ----------------------------------------------------------------------------
// smac_pkg: shared types for the SIMD multiply-accumulate unit
// Opcode codes, lane product bundle and pipeline control bundle.
// ----------------------------------------------------------------------------
`default_nettype none

package smac_pkg;

  // Dword lanes: each covers one 64-bit half of the 128-bit operands
  localparam int unsigned NumLanes = 2;

  typedef enum logic [3:0] {
    OP_MADD      = 4'd0,
    OP_MADDU     = 4'd1,
    OP_PHMADH    = 4'd2,
    OP_PHMSBH    = 4'd3,
    OP_PMADDH    = 4'd4,
    OP_PMADDUW   = 4'd5,
    OP_PMADDW    = 4'd6,
    OP_PMSUBH    = 4'd7,
    OP_PMSUBW    = 4'd8,
    OP_LOAD_HILO = 4'd9
  } smac_op_e;

  // Products found by one dword lane, plus its operand dwords for HI/LO load
  typedef struct packed {
    logic [63:0]      prod_w;
    logic [3:0][31:0] prod_h;
    logic [63:0]      rs;
    logic [63:0]      rt;
  } smac_lane_t;

  typedef struct packed {
    logic     valid;
    smac_op_e op;
  } smac_ctrl_t;

endpackage : smac_pkg

`default_nettype wire

// ----- src/smac_lane.sv -----
// ----------------------------------------------------------------------------
// smac_lane: one dword multiply lane
// Word product of the lane's low word and four halfword products, registered.
// ----------------------------------------------------------------------------
`default_nettype none

module smac_lane
  import smac_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       en_i,
  input  wire smac_op_e   op_i,
  input  wire logic [63:0] rs_i,
  input  wire logic [63:0] rt_i,
  output smac_lane_t      res_o
);

  logic                sgn;
  logic signed [32:0]  a_ext;
  logic signed [32:0]  b_ext;
  logic signed [65:0]  prod_full;
  logic [3:0][31:0]    prod_h;
  smac_lane_t          res_d;
  smac_lane_t          res_q;

  assign sgn = !(op_i == OP_MADDU || op_i == OP_PMADDUW);

  // Extend by one bit so one signed multiplier serves both signednesses
  assign a_ext     = {sgn & rs_i[31], rs_i[31:0]};
  assign b_ext     = {sgn & rt_i[31], rt_i[31:0]};
  assign prod_full = a_ext * b_ext;

  // Sign-extend each halfword to 32 bits before the multiply
  always_comb begin
    for (int j = 0; j < 4; j++) begin
      prod_h[j] = 32'($signed({{16{rs_i[16*j+15]}}, rs_i[16*j +: 16]}) *
                      $signed({{16{rt_i[16*j+15]}}, rt_i[16*j +: 16]}));
    end
  end

  always_comb begin
    res_d.prod_w = prod_full[63:0];
    res_d.prod_h = prod_h;
    res_d.rs     = rs_i;
    res_d.rt     = rt_i;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      res_q <= res_d;
    end
  end

  assign res_o = res_q;

endmodule : smac_lane

`default_nettype wire

// ----- src/smac_accum.sv -----
// ----------------------------------------------------------------------------
// smac_accum: merge stage and HI/LO accumulators
// Combine lane products with HI/LO, update accumulators, hold result word.
// ----------------------------------------------------------------------------
`default_nettype none

module smac_accum
  import smac_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       adv_i,
  input  wire smac_ctrl_t ctrl_i,
  input  wire smac_lane_t [NumLanes-1:0] lane_i,
  output logic            out_valid_o,
  output logic [63:0]     rd_low_o,
  output logic [63:0]     rd_high_o,
  output logic            rd_high_valid_o,
  output logic [63:0]     lo_low_o,
  output logic [63:0]     lo_high_o,
  output logic [63:0]     hi_low_o,
  output logic [63:0]     hi_high_o
);

  logic [3:0][31:0] lo_q, lo_d;
  logic [3:0][31:0] hi_q, hi_d;
  logic [NumLanes-1:0][63:0] rd_q, rd_d;
  logic             rdv_q, rdv_d;
  logic             out_valid_q;

  logic [NumLanes-1:0][63:0]      wsum;
  logic [NumLanes-1:0][1:0][31:0] hsum;
  logic [NumLanes-1:0][3:0][31:0] hacc;
  logic                           w_sgn;

  // Per-lane sums; the opcode picks add or subtract for each
  always_comb begin
    for (int d = 0; d < NumLanes; d++) begin
      if (ctrl_i.op == OP_PMSUBW) begin
        wsum[d] = {hi_q[2*d], lo_q[2*d]} - lane_i[d].prod_w;
      end else begin
        wsum[d] = {hi_q[2*d], lo_q[2*d]} + lane_i[d].prod_w;
      end
      if (ctrl_i.op == OP_PHMSBH) begin
        hsum[d][0] = lane_i[d].prod_h[1] - lane_i[d].prod_h[0];
        hsum[d][1] = lane_i[d].prod_h[3] - lane_i[d].prod_h[2];
      end else begin
        hsum[d][0] = lane_i[d].prod_h[1] + lane_i[d].prod_h[0];
        hsum[d][1] = lane_i[d].prod_h[3] + lane_i[d].prod_h[2];
      end
      if (ctrl_i.op == OP_PMSUBH) begin
        hacc[d][0] = lo_q[2*d]   - lane_i[d].prod_h[0];
        hacc[d][1] = lo_q[2*d+1] - lane_i[d].prod_h[1];
        hacc[d][2] = hi_q[2*d]   - lane_i[d].prod_h[2];
        hacc[d][3] = hi_q[2*d+1] - lane_i[d].prod_h[3];
      end else begin
        hacc[d][0] = lo_q[2*d]   + lane_i[d].prod_h[0];
        hacc[d][1] = lo_q[2*d+1] + lane_i[d].prod_h[1];
        hacc[d][2] = hi_q[2*d]   + lane_i[d].prod_h[2];
        hacc[d][3] = hi_q[2*d+1] + lane_i[d].prod_h[3];
      end
    end
  end

  assign w_sgn = !(ctrl_i.op == OP_MADDU || ctrl_i.op == OP_PMADDUW);

  always_comb begin
    lo_d  = lo_q;
    hi_d  = hi_q;
    rd_d  = '0;
    rdv_d = 1'b0;
    unique case (ctrl_i.op) inside
      OP_MADD, OP_MADDU: begin
        lo_d[0] = wsum[0][31:0];
        hi_d[0] = wsum[0][63:32];
        lo_d[1] = {32{w_sgn & wsum[0][31]}};
        hi_d[1] = {32{w_sgn & wsum[0][63]}};
        rd_d[0] = {lo_d[1], lo_d[0]};
      end
      OP_PMADDW, OP_PMADDUW, OP_PMSUBW: begin
        for (int d = 0; d < NumLanes; d++) begin
          lo_d[2*d]   = wsum[d][31:0];
          hi_d[2*d]   = wsum[d][63:32];
          lo_d[2*d+1] = {32{w_sgn & wsum[d][31]}};
          hi_d[2*d+1] = {32{w_sgn & wsum[d][63]}};
          rd_d[d]     = wsum[d];
        end
        rdv_d = 1'b1;
      end
      OP_PHMADH, OP_PHMSBH: begin
        for (int d = 0; d < NumLanes; d++) begin
          lo_d[2*d] = hsum[d][0];
          hi_d[2*d] = hsum[d][1];
          rd_d[d]   = {hsum[d][1], hsum[d][0]};
        end
        rdv_d = 1'b1;
      end
      OP_PMADDH, OP_PMSUBH: begin
        for (int d = 0; d < NumLanes; d++) begin
          lo_d[2*d]   = hacc[d][0];
          lo_d[2*d+1] = hacc[d][1];
          hi_d[2*d]   = hacc[d][2];
          hi_d[2*d+1] = hacc[d][3];
          rd_d[d]     = {hacc[d][2], hacc[d][0]};
        end
        rdv_d = 1'b1;
      end
      OP_LOAD_HILO: begin
        for (int d = 0; d < NumLanes; d++) begin
          lo_d[2*d]   = lane_i[d].rs[31:0];
          lo_d[2*d+1] = lane_i[d].rs[63:32];
          hi_d[2*d]   = lane_i[d].rt[31:0];
          hi_d[2*d+1] = lane_i[d].rt[63:32];
        end
      end
      default: begin
        // undefined codes: keep HI/LO, zero destination
      end
    endcase
  end

  // Commit only when the word moves into the output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      lo_q        <= '0;
      hi_q        <= '0;
    end else if (adv_i) begin
      out_valid_q <= ctrl_i.valid;
      if (ctrl_i.valid) begin
        lo_q <= lo_d;
        hi_q <= hi_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i && ctrl_i.valid) begin
      rd_q  <= rd_d;
      rdv_q <= rdv_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign rd_low_o        = rd_q[0];
  assign rd_high_o       = rd_q[1];
  assign rd_high_valid_o = rdv_q;
  assign lo_low_o        = lo_q[1:0];
  assign lo_high_o       = lo_q[3:2];
  assign hi_low_o        = hi_q[1:0];
  assign hi_high_o       = hi_q[3:2];

endmodule : smac_accum

`default_nettype wire

// ----- src/simd_multiply_accumulate_unit.sv -----
// ----------------------------------------------------------------------------
// simd_multiply_accumulate_unit: 128-bit HI/LO multiply-accumulate
// Scalar and SIMD multiply-accumulate into HI/LO with a HI/LO load.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one word: an opcode in
//   req_type_i and two 128-bit operands split into low/high dwords.
//   Output channel (out_valid_o / out_stall_i) returns one word per input:
//   the destination value, rd_high_valid_o, and HI/LO after the operation.
//   A word passes two registered stages: one multiply stage in two dword
//   lanes (a 33x33 word product and four 16x16 halfword products each),
//   then the merge stage that adds products into HI/LO and loads the
//   output register. Throughput is one word per cycle while the receiver
//   does not stall; the HI/LO add in the merge stage loops only through
//   the HI/LO registers, so dependent accumulations follow back to back.
//   in_stall_o is raised only when the output register holds a word and
//   the receiver stalls, which freezes both stages; a new word is accepted
//   in the same cycle that a finished one leaves. HI/LO are committed as a
//   word enters the output register, so stalls never change them.
//   Reset clears HI, LO and the stage valid flags; HI/LO read as zero after it.
//   Undefined opcodes keep HI/LO and return a zero destination.
// ----------------------------------------------------------------------------
`default_nettype none

module simd_multiply_accumulate_unit
  import smac_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [3:0]  req_type_i,
  input  wire logic [63:0] rs_low_i,
  input  wire logic [63:0] rs_high_i,
  input  wire logic [63:0] rt_low_i,
  input  wire logic [63:0] rt_high_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [63:0]      rd_low_o,
  output logic [63:0]      rd_high_o,
  output logic             rd_high_valid_o,
  output logic [63:0]      lo_low_o,
  output logic [63:0]      lo_high_o,
  output logic [63:0]      hi_low_o,
  output logic [63:0]      hi_high_o
);

  logic                          adv;
  logic                          lane_en;
  smac_op_e                      op_in;
  smac_ctrl_t                    s1_ctrl_q;
  smac_ctrl_t                    s1_ctrl_d;
  smac_lane_t [NumLanes-1:0]     lane_res;
  logic [NumLanes-1:0][63:0]     rs_dw;
  logic [NumLanes-1:0][63:0]     rt_dw;

  // Whole pipeline advances unless a finished word is held by the receiver
  assign adv        = !(out_valid_o && out_stall_i);
  assign in_stall_o = !adv;
  assign lane_en    = adv && in_valid_i;

  assign op_in = smac_op_e'(req_type_i);
  assign rs_dw = {rs_high_i, rs_low_i};
  assign rt_dw = {rt_high_i, rt_low_i};

  always_comb begin
    s1_ctrl_d.valid = in_valid_i;
    s1_ctrl_d.op    = op_in;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_ctrl_q <= '{valid: 1'b0, op: OP_MADD};
    end else if (adv) begin
      s1_ctrl_q <= s1_ctrl_d;
    end
  end

  for (genvar g = 0; g < NumLanes; g++) begin : g_lane
    smac_lane u_lane (
      .clk_i (clk_i),
      .en_i  (lane_en),
      .op_i  (op_in),
      .rs_i  (rs_dw[g]),
      .rt_i  (rt_dw[g]),
      .res_o (lane_res[g])
    );
  end

  smac_accum u_accum (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .adv_i           (adv),
    .ctrl_i          (s1_ctrl_q),
    .lane_i          (lane_res),
    .out_valid_o     (out_valid_o),
    .rd_low_o        (rd_low_o),
    .rd_high_o       (rd_high_o),
    .rd_high_valid_o (rd_high_valid_o),
    .lo_low_o        (lo_low_o),
    .lo_high_o       (lo_high_o),
    .hi_low_o        (hi_low_o),
    .hi_high_o       (hi_high_o)
  );

endmodule : simd_multiply_accumulate_unit

`default_nettype wire

// ----- src/smac_checker.sv -----
// ----------------------------------------------------------------------------
// smac_checker: port-level checks for the multiply-accumulate unit
// Watches the top-level ports; attached by bind.
// ----------------------------------------------------------------------------
`default_nettype none

module smac_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_stall_o,
  input wire logic        out_valid_o,
  input wire logic        out_stall_i,
  input wire logic [63:0] rd_low_o,
  input wire logic [63:0] rd_high_o,
  input wire logic        rd_high_valid_o,
  input wire logic [63:0] lo_low_o,
  input wire logic [63:0] lo_high_o,
  input wire logic [63:0] hi_low_o,
  input wire logic [63:0] hi_high_o
);

  // Stall input only while a finished word is held
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled without a held output word");

  // Accepted word reaches output if no stall holds the pipeline behind it
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) ##1 !in_stall_o |=> out_valid_o)
    else $error("accepted word did not reach output");

  // Unused destination half reads zero
  a_rd_high_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !rd_high_valid_o) |-> (rd_high_o == 64'd0))
    else $error("rd_high nonzero while not flagged");

  // Held word keeps HI/LO
  a_hold_acc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=>
      ($stable(lo_low_o) && $stable(lo_high_o) && $stable(hi_low_o) &&
       $stable(hi_high_o) && $stable(rd_low_o)))
    else $error("HI/LO changed during output stall");

endmodule : smac_checker

bind simd_multiply_accumulate_unit smac_checker u_smac_checker (.*);

`default_nettype wire
